[sv/rgb_to_hsv_percent_assert.svh]
// ----------------------------------------------------------------------------
// rgb_to_hsv_percent assertion macros
// Shared property templates for the port checker.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PERCENT_ASSERT_SVH
`define RGB_TO_HSV_PERCENT_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define RTHP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RTHP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/rthp_pkg.sv]
// ----------------------------------------------------------------------------
// rthp_pkg
// Types and constants shared by the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rthp_pkg;

    localparam int LVL_W   = 12;                 // clamped channel width
    localparam int IN_W    = 16;                 // raw PWM level width
    localparam int QBITS   = 7;                  // quotient bits, one per cell
    localparam int DSH_W   = LVL_W + QBITS - 1;  // pre-shifted divisor width
    localparam int REM_W   = 19;                 // holds delta*100 for 12-bit delta
    localparam int VPROD_W = 25;                 // 12 x 13 bit product

    localparam logic [LVL_W-1:0] FULL_SCALE_RST = 12'd1000;
    localparam logic [12:0]      VAL_RECIP      = 13'd6554;  // 2^16/10, rounded up
    localparam logic [8:0]       VAL_MAX        = 9'd255;
    localparam logic [REM_W-1:0] HUE_MUL        = 19'd60;
    localparam logic [REM_W-1:0] SAT_MUL        = 19'd100;
    localparam logic [8:0]       HUE_GREEN      = 9'd120;
    localparam logic [8:0]       HUE_BLUE       = 9'd240;
    localparam logic [8:0]       HUE_FULL       = 9'd360;

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    typedef struct packed {
        logic [IN_W-1:0] red_level;
        logic [IN_W-1:0] green_level;
        logic [IN_W-1:0] blue_level;
    } t_pix_in;

    typedef struct packed {
        logic [8:0] hue_deg;
        logic [6:0] sat_pct;
        logic [7:0] val_level;
    } t_hsv_out;

    // state handed from cell to cell
    typedef struct packed {
        logic [1:0]       sector;
        logic             neg;
        logic             hue_zero;
        logic             sat_zero;
        logic [7:0]       val;
        logic [REM_W-1:0] rem_h;
        logic [DSH_W-1:0] dsh_h;
        logic [QBITS-1:0] q_h;
        logic [REM_W-1:0] rem_s;
        logic [DSH_W-1:0] dsh_s;
        logic [QBITS-1:0] q_s;
    } t_div;

endpackage

[sv/rthp_front.sv]
// ----------------------------------------------------------------------------
// rthp_front
// Clamp, max/min/sector selection and divider operand setup (two stages).
// ----------------------------------------------------------------------------
module rthp_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rthp_pkg::LVL_W-1:0] i_full_scale,
    input  logic                       i_valid,
    input  rthp_pkg::t_pix_in          i_data,
    output logic                       o_ready,
    output logic                       o_valid,
    output rthp_pkg::t_div             o_data,
    input  logic                       i_ready
);

    logic                       r_s1_valid;
    logic [rthp_pkg::LVL_W-1:0] r_r, r_g, r_b;
    logic                       r_s2_valid;
    rthp_pkg::t_div             r_s2;

    logic                       s1_ready, s2_ready;
    logic [rthp_pkg::LVL_W-1:0] n_r, n_g, n_b;
    logic [rthp_pkg::LVL_W-1:0] mx, mn, delta, op_a, op_b, absd;
    logic [1:0]                 sec;
    logic                       neg;
    logic [rthp_pkg::VPROD_W-1:0] vprod;
    logic [8:0]                 val9;
    rthp_pkg::t_div             n_s2;

    function automatic logic [rthp_pkg::LVL_W-1:0] clamp(
        input logic [rthp_pkg::IN_W-1:0]  lvl,
        input logic [rthp_pkg::LVL_W-1:0] fs
    );
        logic [rthp_pkg::IN_W-1:0] fs_w;
        fs_w = rthp_pkg::IN_W'(fs);
        return (lvl > fs_w) ? fs : lvl[rthp_pkg::LVL_W-1:0];
    endfunction

    assign s2_ready = !r_s2_valid || i_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_ready  = s1_ready;
    assign o_valid  = r_s2_valid;
    assign o_data   = r_s2;

    assign n_r = clamp(i_data.red_level,   i_full_scale);
    assign n_g = clamp(i_data.green_level, i_full_scale);
    assign n_b = clamp(i_data.blue_level,  i_full_scale);

    always_comb begin
        // ties go to red, then green
        if (r_r >= r_g && r_r >= r_b) begin
            sec  = rthp_pkg::SEC_RED;
            mx   = r_r;
            op_a = r_g;
            op_b = r_b;
        end else if (r_g >= r_b) begin
            sec  = rthp_pkg::SEC_GREEN;
            mx   = r_g;
            op_a = r_b;
            op_b = r_r;
        end else begin
            sec  = rthp_pkg::SEC_BLUE;
            mx   = r_b;
            op_a = r_r;
            op_b = r_g;
        end
        mn = r_r;
        if (r_g < mn) mn = r_g;
        if (r_b < mn) mn = r_b;
        delta = mx - mn;
        neg   = op_a < op_b;
        absd  = neg ? (op_b - op_a) : (op_a - op_b);

        // max/10 by reciprocal, exact for inputs below 16384
        vprod = rthp_pkg::VPROD_W'(mx) * rthp_pkg::VPROD_W'(rthp_pkg::VAL_RECIP);
        val9  = vprod[rthp_pkg::VPROD_W-1:16];

        n_s2.sector   = sec;
        n_s2.neg      = neg;
        n_s2.hue_zero = (delta == '0);
        n_s2.sat_zero = (mx == '0);
        n_s2.val      = (val9 > rthp_pkg::VAL_MAX) ? 8'hFF : val9[7:0];
        n_s2.rem_h    = rthp_pkg::REM_W'(absd) * rthp_pkg::HUE_MUL;
        n_s2.dsh_h    = {delta, {(rthp_pkg::QBITS-1){1'b0}}};
        n_s2.q_h      = '0;
        n_s2.rem_s    = rthp_pkg::REM_W'(delta) * rthp_pkg::SAT_MUL;
        n_s2.dsh_s    = {mx, {(rthp_pkg::QBITS-1){1'b0}}};
        n_s2.q_s      = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) r_s1_valid <= i_valid;
            if (s2_ready) r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_r <= n_r;
            r_g <= n_g;
            r_b <= n_b;
        end
        if (s2_ready && r_s1_valid) r_s2 <= n_s2;
    end

endmodule

[sv/rthp_div_cell.sv]
// ----------------------------------------------------------------------------
// rthp_div_cell
// One restoring-division step for the hue and saturation quotients.
// ----------------------------------------------------------------------------
module rthp_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rthp_pkg::t_div i_data,
    output logic           o_ready,
    output logic           o_valid,
    output rthp_pkg::t_div o_data,
    input  logic           i_ready
);

    logic           r_valid;
    rthp_pkg::t_div r_data;
    rthp_pkg::t_div n_data;
    logic           ge_h, ge_s;
    logic           ready;

    assign ready   = !r_valid || i_ready;
    assign o_ready = ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        ge_h = i_data.rem_h >= rthp_pkg::REM_W'(i_data.dsh_h);
        ge_s = i_data.rem_s >= rthp_pkg::REM_W'(i_data.dsh_s);

        n_data       = i_data;
        n_data.rem_h = ge_h ? (i_data.rem_h - rthp_pkg::REM_W'(i_data.dsh_h)) : i_data.rem_h;
        n_data.rem_s = ge_s ? (i_data.rem_s - rthp_pkg::REM_W'(i_data.dsh_s)) : i_data.rem_s;
        n_data.dsh_h = i_data.dsh_h >> 1;
        n_data.dsh_s = i_data.dsh_s >> 1;
        n_data.q_h   = {i_data.q_h[rthp_pkg::QBITS-2:0], ge_h};
        n_data.q_s   = {i_data.q_s[rthp_pkg::QBITS-2:0], ge_s};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) r_data <= n_data;
    end

endmodule

[sv/rgb_to_hsv_percent.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_percent
// RGB PWM triple to hue (degrees), saturation (percent) and value (max/10).
// ----------------------------------------------------------------------------
// Takes one beat per clock while not stalled and returns one result beat
// per input beat, in order. A beat passes through two front stages (clamp,
// then max/min and operand setup), a chain of seven divider cells that each
// resolve one quotient bit of hue and saturation, and the output register.
// Every stage holds its beat under stall and a stage with a bubble keeps
// filling, so the input is stalled only once all ten stages are full. The
// user must write full_scale through i_cfg_we/i_cfg_data only while no beats
// are in flight; the block does not enforce this. It resets to 1000.
module rgb_to_hsv_percent (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rthp_pkg::LVL_W-1:0] i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  rthp_pkg::t_pix_in          i_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output rthp_pkg::t_hsv_out         o_data
);

    localparam int NC = rthp_pkg::QBITS;

    logic [rthp_pkg::LVL_W-1:0] r_full_scale;
    logic                       r_out_valid;
    rthp_pkg::t_hsv_out         r_out;

    rthp_pkg::t_div   cd    [0:NC];
    logic             cv    [0:NC];
    logic             rdy   [0:NC];
    logic             in_ready;
    logic             out_ready;
    rthp_pkg::t_hsv_out n_out;
    logic [8:0]       q9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= rthp_pkg::FULL_SCALE_RST;
        end else if (i_cfg_we) begin
            r_full_scale <= i_cfg_data;
        end
    end

    rthp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_full_scale (r_full_scale),
        .i_valid      (i_valid),
        .i_data       (i_data),
        .o_ready      (in_ready),
        .o_valid      (cv[0]),
        .o_data       (cd[0]),
        .i_ready      (rdy[0])
    );

    for (genvar k = 0; k < NC; k++) begin : g_cell
        rthp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cv[k]),
            .i_data  (cd[k]),
            .o_ready (rdy[k]),
            .o_valid (cv[k+1]),
            .o_data  (cd[k+1]),
            .i_ready (rdy[k+1])
        );
    end

    assign out_ready = !r_out_valid || !i_stall;
    assign rdy[NC]   = out_ready;
    assign o_stall   = !in_ready;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    always_comb begin
        q9 = 9'(cd[NC].q_h);
        n_out.val_level = cd[NC].val;
        n_out.sat_pct   = cd[NC].sat_zero ? 7'd0 : cd[NC].q_s;
        n_out.hue_deg   = '0;
        if (!cd[NC].hue_zero) begin
            case (cd[NC].sector)
                rthp_pkg::SEC_RED: begin
                    // negative red-sector hue wraps; a zero quotient lands on 0
                    if (cd[NC].neg && q9 != '0) n_out.hue_deg = rthp_pkg::HUE_FULL - q9;
                    else if (!cd[NC].neg)       n_out.hue_deg = q9;
                end
                rthp_pkg::SEC_GREEN: begin
                    n_out.hue_deg = cd[NC].neg ? (rthp_pkg::HUE_GREEN - q9)
                                               : (rthp_pkg::HUE_GREEN + q9);
                end
                default: begin
                    n_out.hue_deg = cd[NC].neg ? (rthp_pkg::HUE_BLUE - q9)
                                               : (rthp_pkg::HUE_BLUE + q9);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= cv[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && cv[NC]) r_out <= n_out;
    end

endmodule

[sv/rthp_check.sv]
// ----------------------------------------------------------------------------
// rthp_check
// Port-level checker for the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_percent_assert.svh"

module rthp_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rthp_pkg::LVL_W-1:0] i_cfg_data,
    input  logic                       i_valid,
    input  logic                       o_stall,
    input  rthp_pkg::t_pix_in          i_data,
    input  logic                       o_valid,
    input  logic                       i_stall,
    input  rthp_pkg::t_hsv_out         o_data
);

    logic unused_ok;
    assign unused_ok = i_cfg_we ^ (^i_cfg_data) ^ i_valid ^ o_stall ^ (^i_data);

    `RTHP_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_data), "stalled result beat changed")
    `RTHP_ASSERT_IMP(a_hue_range, o_valid, o_data.hue_deg < rthp_pkg::HUE_FULL, "hue out of range")
    `RTHP_ASSERT_IMP(a_sat_range, o_valid, o_data.sat_pct <= 7'd100, "saturation above 100")

endmodule

bind rgb_to_hsv_percent rthp_check u_rthp_check (.*);
